@@ design/fmbq_pkg.sv @@
`default_nettype none

package fmbq_pkg;

  // Storage geometry
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Beat fields
  localparam int DATA_W      = 32;
  localparam int KIND_W      = 3;
  localparam int COUNT_W     = 11;
  localparam int IN_TDATA_W  = ((DATA_W + 7) / 8) * 8;
  localparam int IN_TUSER_W  = KIND_W;
  localparam int OUT_BITS    = DATA_W + 2 + COUNT_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT  = 3'd0,
    K_PUSH_MIDDLE = 3'd1,
    K_PUSH_BACK   = 3'd2,
    K_POP_FRONT   = 3'd3,
    K_POP_MIDDLE  = 3'd4,
    K_POP_BACK    = 3'd5
  } kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Write data select: the beat's value, or the other half's read data
  typedef enum logic {
    WSRC_VALUE,
    WSRC_OTHER
  } wsrc_t;

  typedef enum logic [1:0] {
    RES_ZERO,
    RES_NEG1,
    RES_FRONT,
    RES_BACK
  } res_t;

  // Decoded operation, held from accept until commit
  typedef struct packed {
    logic              f_we;
    logic [ADDR_W-1:0] f_waddr;
    wsrc_t             f_wsrc;
    logic              b_we;
    logic [ADDR_W-1:0] b_waddr;
    wsrc_t             b_wsrc;
    res_t              res_src;
    logic              empty;
    logic              full;
    logic [ADDR_W-1:0] fh;
    logic [CNT_W-1:0]  fc;
    logic [ADDR_W-1:0] bh;
    logic [CNT_W-1:0]  bc;
    logic [DATA_W-1:0] value;
  } plan_t;

  // head + off around the ring; off is below CAPACITY
  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] h,
                                                 input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(h) + (CNT_W+1)'(off);
    if (sum >= (CNT_W+1)'(CAPACITY)) begin
      sum = sum - (CNT_W+1)'(CAPACITY);
    end
    return sum[ADDR_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] ring_dec(input logic [ADDR_W-1:0] h);
    logic [ADDR_W-1:0] r;
    if (h == '0) begin
      r = ADDR_W'(CAPACITY - 1);
    end else begin
      r = h - ADDR_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/fmbq_ram.sv @@
`default_nettype none

// Simple dual-port RAM, registered read
module fmbq_ram (
  input  wire                          clk,
  input  wire                          wr_en,
  input  wire [fmbq_pkg::ADDR_W-1:0]   wr_addr,
  input  wire [fmbq_pkg::DATA_W-1:0]   wr_data,
  input  wire                          rd_en,
  input  wire [fmbq_pkg::ADDR_W-1:0]   rd_addr,
  output logic [fmbq_pkg::DATA_W-1:0]  rd_data
);

  logic [fmbq_pkg::DATA_W-1:0] mem [fmbq_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/front_middle_back_queue.sv @@
`default_nettype none

// Channel   Dir  Fields (lowest bit up)
// s_*       in   tdata: value_in[31:0]; tuser: kind[2:0]
// m_*       out  tdata: value_out[31:0], was_empty, was_full, count_after[10:0], pad
//
// Each beat has an accept cycle and a commit cycle: the accept cycle issues
// at most one read per half memory, the commit cycle writes back at most one
// entry per half and loads the result register, since the RAM read is registered.
// A result that is not taken holds the block in its commit cycle; the next
// beat is not accepted until the previous one has committed.
// Reset clears heads, counts, state and m_tvalid; the memories are not cleared.
module front_middle_back_queue (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  input  wire  [fmbq_pkg::IN_TDATA_W-1:0]     s_tdata,   // value_in
  input  wire  [fmbq_pkg::IN_TUSER_W-1:0]     s_tuser,   // kind
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  output logic [fmbq_pkg::OUT_TDATA_W-1:0]    m_tdata    // value_out, was_empty,
                                                         // was_full, count_after
);

  // Ring pointers for the two halves
  logic [fmbq_pkg::ADDR_W-1:0] fh;
  logic [fmbq_pkg::CNT_W-1:0]  fc;
  logic [fmbq_pkg::ADDR_W-1:0] bh;
  logic [fmbq_pkg::CNT_W-1:0]  bc;

  fmbq_pkg::state_t state;
  fmbq_pkg::state_t state_next;

  fmbq_pkg::plan_t plan;
  fmbq_pkg::plan_t plan_next;

  logic accept;
  logic commit;
  logic out_free;

  // Memory ports
  logic                        f_rd_en;
  logic [fmbq_pkg::ADDR_W-1:0] f_rd_addr;
  logic [fmbq_pkg::DATA_W-1:0] f_rd_data;
  logic [fmbq_pkg::DATA_W-1:0] f_wr_data;
  logic                        b_rd_en;
  logic [fmbq_pkg::ADDR_W-1:0] b_rd_addr;
  logic [fmbq_pkg::DATA_W-1:0] b_rd_data;
  logic [fmbq_pkg::DATA_W-1:0] b_wr_data;

  // Derived positions from the current pointers
  logic [fmbq_pkg::CNT_W:0]    total;
  logic                        bal_eq;      // halves equal; otherwise front is one larger
  logic [fmbq_pkg::ADDR_W-1:0] front_tail;
  logic [fmbq_pkg::ADDR_W-1:0] front_end;
  logic [fmbq_pkg::ADDR_W-1:0] back_tail;
  logic [fmbq_pkg::ADDR_W-1:0] back_end;
  logic [fmbq_pkg::ADDR_W-1:0] fh_dec;
  logic [fmbq_pkg::ADDR_W-1:0] bh_dec;
  logic [fmbq_pkg::ADDR_W-1:0] fh_inc;
  logic [fmbq_pkg::ADDR_W-1:0] bh_inc;

  logic [fmbq_pkg::DATA_W-1:0]  res_value;
  logic [fmbq_pkg::CNT_W:0]     sum_after;
  logic [fmbq_pkg::COUNT_W-1:0] count_after;

  assign total      = (fmbq_pkg::CNT_W+1)'(fc) + (fmbq_pkg::CNT_W+1)'(bc);
  assign bal_eq     = (fc == bc);
  assign front_tail = fmbq_pkg::ring_add(fh, fc - fmbq_pkg::CNT_W'(1));
  assign front_end  = fmbq_pkg::ring_add(fh, fc);
  assign back_tail  = fmbq_pkg::ring_add(bh, bc - fmbq_pkg::CNT_W'(1));
  assign back_end   = fmbq_pkg::ring_add(bh, bc);
  assign fh_dec     = fmbq_pkg::ring_dec(fh);
  assign bh_dec     = fmbq_pkg::ring_dec(bh);
  assign fh_inc     = fmbq_pkg::ring_add(fh, fmbq_pkg::CNT_W'(1));
  assign bh_inc     = fmbq_pkg::ring_add(bh, fmbq_pkg::CNT_W'(1));

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Decode: pick reads for this cycle and the writes/pointers for commit.
  // Every operation needs at most one read and one write per half, and at
  // most one element crossing between halves.
  always_comb begin
    plan_next         = plan;
    plan_next.f_we    = 1'b0;
    plan_next.f_waddr = front_end;
    plan_next.f_wsrc  = fmbq_pkg::WSRC_VALUE;
    plan_next.b_we    = 1'b0;
    plan_next.b_waddr = back_end;
    plan_next.b_wsrc  = fmbq_pkg::WSRC_VALUE;
    plan_next.res_src = fmbq_pkg::RES_ZERO;
    plan_next.empty   = 1'b0;
    plan_next.full    = 1'b0;
    plan_next.fh      = fh;
    plan_next.fc      = fc;
    plan_next.bh      = bh;
    plan_next.bc      = bc;
    plan_next.value   = s_tdata[fmbq_pkg::DATA_W-1:0];
    f_rd_en           = 1'b0;
    f_rd_addr         = fh;
    b_rd_en           = 1'b0;
    b_rd_addr         = bh;

    case (fmbq_pkg::kind_t'(s_tuser[fmbq_pkg::KIND_W-1:0]))
      fmbq_pkg::K_PUSH_FRONT: begin
        if (total >= (fmbq_pkg::CNT_W+1)'(fmbq_pkg::CAPACITY)) begin
          plan_next.full = 1'b1;
        end else begin
          plan_next.f_we    = 1'b1;
          plan_next.f_waddr = fh_dec;
          plan_next.fh      = fh_dec;
          if (bal_eq) begin
            plan_next.fc = fc + fmbq_pkg::CNT_W'(1);
          end else begin
            // front would be two ahead: its tail moves to the back's head
            f_rd_en           = 1'b1;
            f_rd_addr         = front_tail;
            plan_next.b_we    = 1'b1;
            plan_next.b_waddr = bh_dec;
            plan_next.b_wsrc  = fmbq_pkg::WSRC_OTHER;
            plan_next.bh      = bh_dec;
            plan_next.bc      = bc + fmbq_pkg::CNT_W'(1);
          end
        end
      end
      fmbq_pkg::K_PUSH_MIDDLE: begin
        if (total >= (fmbq_pkg::CNT_W+1)'(fmbq_pkg::CAPACITY)) begin
          plan_next.full = 1'b1;
        end else begin
          plan_next.f_we = 1'b1;
          if (bal_eq) begin
            plan_next.f_waddr = front_end;
            plan_next.fc      = fc + fmbq_pkg::CNT_W'(1);
          end else begin
            // odd count: front tail moves over, new value takes its slot
            f_rd_en           = 1'b1;
            f_rd_addr         = front_tail;
            plan_next.f_waddr = front_tail;
            plan_next.b_we    = 1'b1;
            plan_next.b_waddr = bh_dec;
            plan_next.b_wsrc  = fmbq_pkg::WSRC_OTHER;
            plan_next.bh      = bh_dec;
            plan_next.bc      = bc + fmbq_pkg::CNT_W'(1);
          end
        end
      end
      fmbq_pkg::K_PUSH_BACK: begin
        if (total >= (fmbq_pkg::CNT_W+1)'(fmbq_pkg::CAPACITY)) begin
          plan_next.full = 1'b1;
        end else if (!bal_eq) begin
          plan_next.b_we    = 1'b1;
          plan_next.b_waddr = back_end;
          plan_next.bc      = bc + fmbq_pkg::CNT_W'(1);
        end else if (bc == '0) begin
          // empty queue: value lands straight in the front half
          plan_next.f_we    = 1'b1;
          plan_next.f_waddr = front_end;
          plan_next.fc      = fc + fmbq_pkg::CNT_W'(1);
        end else begin
          // back head moves to the front tail, value appended to the back
          b_rd_en           = 1'b1;
          b_rd_addr         = bh;
          plan_next.f_we    = 1'b1;
          plan_next.f_waddr = front_end;
          plan_next.f_wsrc  = fmbq_pkg::WSRC_OTHER;
          plan_next.fc      = fc + fmbq_pkg::CNT_W'(1);
          plan_next.b_we    = 1'b1;
          plan_next.b_waddr = back_end;
          plan_next.bh      = bh_inc;
        end
      end
      fmbq_pkg::K_POP_FRONT: begin
        if (total == '0) begin
          plan_next.empty   = 1'b1;
          plan_next.res_src = fmbq_pkg::RES_NEG1;
        end else begin
          f_rd_en           = 1'b1;
          f_rd_addr         = fh;
          plan_next.res_src = fmbq_pkg::RES_FRONT;
          plan_next.fh      = fh_inc;
          if (bal_eq) begin
            // refill the front tail from the back head
            b_rd_en           = 1'b1;
            b_rd_addr         = bh;
            plan_next.f_we    = 1'b1;
            plan_next.f_waddr = front_end;
            plan_next.f_wsrc  = fmbq_pkg::WSRC_OTHER;
            plan_next.bh      = bh_inc;
            plan_next.bc      = bc - fmbq_pkg::CNT_W'(1);
          end else begin
            plan_next.fc = fc - fmbq_pkg::CNT_W'(1);
          end
        end
      end
      fmbq_pkg::K_POP_MIDDLE: begin
        if (total == '0) begin
          plan_next.empty   = 1'b1;
          plan_next.res_src = fmbq_pkg::RES_NEG1;
        end else begin
          f_rd_en           = 1'b1;
          f_rd_addr         = front_tail;
          plan_next.res_src = fmbq_pkg::RES_FRONT;
          if (bal_eq) begin
            // back head takes over the vacated front tail slot
            b_rd_en           = 1'b1;
            b_rd_addr         = bh;
            plan_next.f_we    = 1'b1;
            plan_next.f_waddr = front_tail;
            plan_next.f_wsrc  = fmbq_pkg::WSRC_OTHER;
            plan_next.bh      = bh_inc;
            plan_next.bc      = bc - fmbq_pkg::CNT_W'(1);
          end else begin
            plan_next.fc = fc - fmbq_pkg::CNT_W'(1);
          end
        end
      end
      fmbq_pkg::K_POP_BACK: begin
        if (total == '0) begin
          plan_next.empty   = 1'b1;
          plan_next.res_src = fmbq_pkg::RES_NEG1;
        end else if (bc == '0) begin
          // single element, held in the front half
          f_rd_en           = 1'b1;
          f_rd_addr         = fh;
          plan_next.res_src = fmbq_pkg::RES_FRONT;
          plan_next.fc      = fc - fmbq_pkg::CNT_W'(1);
        end else begin
          b_rd_en           = 1'b1;
          b_rd_addr         = back_tail;
          plan_next.res_src = fmbq_pkg::RES_BACK;
          if (bal_eq) begin
            plan_next.bc = bc - fmbq_pkg::CNT_W'(1);
          end else begin
            // front tail slides over to the back head
            f_rd_en           = 1'b1;
            f_rd_addr         = front_tail;
            plan_next.fc      = fc - fmbq_pkg::CNT_W'(1);
            plan_next.b_we    = 1'b1;
            plan_next.b_waddr = bh_dec;
            plan_next.b_wsrc  = fmbq_pkg::WSRC_OTHER;
            plan_next.bh      = bh_dec;
          end
        end
      end
      default: begin
        // unused kinds: no change, zero result
      end
    endcase
  end

  // Reads issue only on accept, so read data holds through an output stall.
  // Writes happen only at commit, never in the same cycle as a read.
  fmbq_ram u_front_ram (
    .clk     (clk),
    .wr_en   (commit && plan.f_we),
    .wr_addr (plan.f_waddr),
    .wr_data (f_wr_data),
    .rd_en   (accept && f_rd_en),
    .rd_addr (f_rd_addr),
    .rd_data (f_rd_data)
  );

  fmbq_ram u_back_ram (
    .clk     (clk),
    .wr_en   (commit && plan.b_we),
    .wr_addr (plan.b_waddr),
    .wr_data (b_wr_data),
    .rd_en   (accept && b_rd_en),
    .rd_addr (b_rd_addr),
    .rd_data (b_rd_data)
  );

  assign f_wr_data = (plan.f_wsrc == fmbq_pkg::WSRC_OTHER) ? b_rd_data : plan.value;
  assign b_wr_data = (plan.b_wsrc == fmbq_pkg::WSRC_OTHER) ? f_rd_data : plan.value;

  always_comb begin
    case (plan.res_src)
      fmbq_pkg::RES_NEG1:  res_value = {fmbq_pkg::DATA_W{1'b1}};
      fmbq_pkg::RES_FRONT: res_value = f_rd_data;
      fmbq_pkg::RES_BACK:  res_value = b_rd_data;
      default:             res_value = '0;
    endcase
  end

  assign sum_after   = (fmbq_pkg::CNT_W+1)'(plan.fc) + (fmbq_pkg::CNT_W+1)'(plan.bc);
  assign count_after = fmbq_pkg::COUNT_W'(sum_after);

  // FSM: next state
  always_comb begin
    state_next = state;
    case (state)
      fmbq_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = fmbq_pkg::ST_EXEC;
        end
      end
      fmbq_pkg::ST_EXEC: begin
        if (out_free) begin
          state_next = fmbq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = fmbq_pkg::ST_IDLE;
      end
    endcase
  end

  // FSM: outputs
  always_comb begin
    s_tready = 1'b0;
    commit   = 1'b0;
    case (state)
      fmbq_pkg::ST_IDLE: s_tready = 1'b1;
      fmbq_pkg::ST_EXEC: commit   = out_free;
      default: begin
        s_tready = 1'b0;
        commit   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= fmbq_pkg::ST_IDLE;
      fh       <= '0;
      fc       <= '0;
      bh       <= '0;
      bc       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (commit) begin
        fh       <= plan.fh;
        fc       <= plan.fc;
        bh       <= plan.bh;
        bc       <= plan.bc;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      plan <= plan_next;
    end
    if (commit) begin
      m_tdata <= fmbq_pkg::OUT_TDATA_W'({count_after, plan.full, plan.empty, res_value});
    end
  end

endmodule

`default_nettype wire
